// ===== hdl/brf_pkg.sv =====
// Shared types, codes and widths for the byte ring FIFO.
package brf_pkg;

  localparam int DATA_W  = 8;
  localparam int CAP_W   = 7;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET    = 7'd64;
  localparam logic [PADDR_W-1:0] REG_CAPACITY = 2'd0;

  localparam logic [1:0] MODE_PUSH      = 2'd0;
  localparam logic [1:0] MODE_OVERWRITE = 2'd1;
  localparam logic [1:0] MODE_READ      = 2'd2;
  localparam logic [1:0] MODE_CLEAR     = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_item;  // latch the incoming transfer
    logic rd_head;    // RAM read address selects the head slot
    logic exec;       // apply the operation to store and pointers
    logic load_out;   // move the result into the output register
  } brf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } brf_stat_t;

endpackage

// ===== hdl/brf_channels.sv =====
// Handshake channel interfaces for operations and results.
interface brf_cmd_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output mode, output write_data, input ready);
  modport sink (input valid, input mode, input write_data, output ready);
endinterface

interface brf_rsp_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] read_data;
  logic [CAP_W-1:0]  occupancy;
  logic              is_empty;
  logic              is_full;
  logic [DATA_W-1:0] newest_data;

  modport source (output valid, output status, output read_data, output occupancy,
                  output is_empty, output is_full, output newest_data, input ready);
  modport sink (input valid, input status, input read_data, input occupancy,
                input is_empty, input is_full, input newest_data, output ready);
endinterface

// ===== hdl/byte_ring_fifo_overwrite.sv =====
// Top level of the byte ring FIFO with overwrite.
//
//   channel  dir  handshake          payload
//   cmd      in   valid/ready        mode, write_data
//   rsp      out  valid/ready        status, read_data, occupancy, is_empty,
//                                    is_full, newest_data
//   apb      in   psel/penable       capacity register at byte address 0
//
// An operation steps through accept, execute, fetch and deliver; no new one
// is taken until the last has delivered: the slot RAM has one read port, read
// first at the head slot and then at the slot before the new tail.
// A result waiting in the output register does not block the next transfer;
// that operation holds in its last step until the result is taken.
// Reset (rst, synchronous) clears all slot valid bits at once, so the store
// reads as zero right away and there is no clearing pass.
module byte_ring_fifo_overwrite import brf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  brf_cmd_if.sink             cmd,
  brf_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  brf_cmd_t         ctrl_cmd;
  brf_stat_t        ctrl_stat;
  logic             cap_we;
  logic [CAP_W-1:0] cap_value;

  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && (paddr == REG_CAPACITY);
  assign prdata = (paddr == REG_CAPACITY) ? PDATA_W'(cap_value) : '0;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (ctrl_stat),
    .cmd      (ctrl_cmd)
  );

  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctrl_cmd),
    .stat            (ctrl_stat),
    .mode            (cmd.mode),
    .write_data      (cmd.write_data),
    .cap_we          (cap_we),
    .cap_wdata       (pwdata[CAP_W-1:0]),
    .cap_value       (cap_value),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_read_data   (rsp.read_data),
    .out_occupancy   (rsp.occupancy),
    .out_is_empty    (rsp.is_empty),
    .out_is_full     (rsp.is_full),
    .out_newest_data (rsp.newest_data)
  );

  // one operation in flight: no transfer in the cycle after a transfer
  assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("cmd accepted while an operation was in flight");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("result flagged both empty and full");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |-> (rsp.occupancy == '0))
    else $error("empty result with nonzero occupancy");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_FULL)) |-> (rsp.is_full && (rsp.read_data == '0)))
    else $error("rejected push reported while not full");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_EMPTY)) |-> (rsp.is_empty && (rsp.read_data == '0)))
    else $error("empty read reported while data stored");

endmodule

// ===== hdl/brf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/brf_ctrl.sv =====
// Sequencer for the byte ring FIFO: accept, execute, fetch newest slot, deliver.
module brf_ctrl import brf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  brf_stat_t stat,
  output brf_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.rd_head   = 1'b0;
    cmd.exec      = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.rd_head   = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/brf_datapath.sv =====
// Byte ring FIFO datapath: slot RAM, valid bits, pointers, capacity and result register.
module brf_datapath import brf_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  brf_cmd_t          cmd,
  output brf_stat_t         stat,
  input  logic [1:0]        mode,
  input  logic [DATA_W-1:0] write_data,
  input  logic              cap_we,
  input  logic [CAP_W-1:0]  cap_wdata,
  output logic [CAP_W-1:0]  cap_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [DATA_W-1:0] out_read_data,
  output logic [CAP_W-1:0]  out_occupancy,
  output logic              out_is_empty,
  output logic              out_is_full,
  output logic [DATA_W-1:0] out_newest_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CAP_W-1:0]  capacity;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic              full;
  logic [DEPTH-1:0]  valid;
  logic [1:0]        mode_q;
  logic [DATA_W-1:0] data_q;
  logic [1:0]        status_q;
  logic [DATA_W-1:0] rd_q;

  logic [CW-1:0]     cap_ext;
  logic [CW-1:0]     eff_cap;
  logic [CW-1:0]     occ;
  logic [CW-1:0]     last_wrap;
  logic [PTR_W-1:0]  last_idx;
  logic [PTR_W-1:0]  head_adv;
  logic [PTR_W-1:0]  tail_adv;
  logic              empty;
  logic              is_write;
  logic              ram_we;
  logic [PTR_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CW-1:0] cap);
    logic [CW-1:0] nx;
    nx = CW'(p) + CW'(1);
    return (nx >= cap) ? '0 : nx[PTR_W-1:0];
  endfunction

  // saturate the register to 1 .. DEPTH
  assign cap_ext = CW'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign head_adv = advance(head, eff_cap);
  assign tail_adv = advance(tail, eff_cap);
  assign empty    = (head == tail) && !full;

  always_comb begin
    if (full) begin
      occ = eff_cap;
    end else if (head <= tail) begin
      occ = CW'(tail) - CW'(head);
    end else begin
      occ = eff_cap - (CW'(head) - CW'(tail));
    end
  end

  assign last_wrap = eff_cap - CW'(1);
  assign last_idx  = (tail == '0) ? last_wrap[PTR_W-1:0] : tail - PTR_W'(1);

  assign is_write = (mode_q == MODE_PUSH) || (mode_q == MODE_OVERWRITE);
  // when full, head equals tail, so the tail address serves both push forms
  assign ram_we   = cmd.exec && is_write && (!full || (mode_q == MODE_OVERWRITE));
  assign raddr    = cmd.rd_head ? head : last_idx;

  brf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (data_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_q <= mode;
      data_q <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      full     <= 1'b0;
      valid    <= '0;
    end else if (cap_we) begin
      capacity <= cap_wdata;
      head     <= '0;
      tail     <= '0;
      full     <= 1'b0;
    end else if (cmd.exec) begin
      unique case (mode_q)
        MODE_PUSH, MODE_OVERWRITE: begin
          rd_q <= '0;
          if (!full) begin
            status_q    <= ST_DONE;
            valid[tail] <= 1'b1;
            tail        <= tail_adv;
            full        <= (head == tail_adv);
          end else if (mode_q == MODE_OVERWRITE) begin
            status_q    <= ST_DONE;
            valid[tail] <= 1'b1;
            head        <= head_adv;
            tail        <= tail_adv;
          end else begin
            status_q <= ST_FULL;
          end
        end
        MODE_READ: begin
          if (empty) begin
            status_q <= ST_EMPTY;
            rd_q     <= '0;
          end else begin
            status_q    <= ST_DONE;
            // drop the valid bit: the slot now reads as zero
            rd_q        <= valid[head] ? rdata : '0;
            valid[head] <= 1'b0;
            head        <= head_adv;
            full        <= 1'b0;
          end
        end
        MODE_CLEAR: begin
          status_q <= ST_DONE;
          rd_q     <= '0;
          head     <= '0;
          tail     <= '0;
          full     <= 1'b0;
          for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) < eff_cap) begin
              valid[i] <= 1'b0;
            end
          end
        end
        default: begin
          status_q <= ST_DONE;
          rd_q     <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= status_q;
      out_read_data   <= rd_q;
      out_occupancy   <= occ[CAP_W-1:0];
      out_is_empty    <= empty;
      out_is_full     <= full;
      out_newest_data <= valid[last_idx] ? rdata : '0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign cap_value     = capacity;

endmodule

// ===== test/tb_byte_ring_fifo_overwrite.sv =====
// Self-checking testbench for the byte ring FIFO with overwrite.
`timescale 1ns / 100ps

module tb_byte_ring_fifo_overwrite;
  import brf_pkg::*;

  localparam int RING_DEPTH  = 64;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] read_data;
    logic [CAP_W-1:0]  occupancy;
    logic              is_empty;
    logic              is_full;
    logic [DATA_W-1:0] newest_data;
  } fifo_rsp_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  brf_cmd_if cmd_ch ();
  brf_rsp_if rsp_ch ();

  byte_ring_fifo_overwrite #(.DEPTH(RING_DEPTH)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ring state as the block should hold it
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  bit                ring_full;
  logic [CAP_W-1:0]  cap_reg;

  fifo_rsp_t expected_rsp_q [$];

  int idle_pct;
  int stall_pct;
  bit hold_req;

  int n_fail;
  int n_items;
  int n_results;
  int n_cfg;
  int n_reject;
  int n_empty_rd;
  int n_ovw;
  int n_clear;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous: several times the slowest legal run
  initial begin
    #400_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned ring_cap();
    if (cap_reg < 1) return 1;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= ring_cap()) ? 0 : p + 1;
  endfunction

  function automatic bit ring_empty();
    return (ring_head == ring_tail) && !ring_full;
  endfunction

  function automatic int unsigned ring_count();
    if (ring_full) return ring_cap();
    if (ring_head <= ring_tail) return ring_tail - ring_head;
    return ring_cap() - (ring_head - ring_tail);
  endfunction

  function automatic void ring_restart();
    ring_head = 0;
    ring_tail = 0;
    ring_full = 1'b0;
  endfunction

  function automatic fifo_rsp_t ring_step(input logic [1:0] op, input logic [DATA_W-1:0] wd);
    fifo_rsp_t   r;
    int unsigned cap;
    int unsigned last;
    cap = ring_cap();
    r = '0;
    r.status = ST_DONE;
    case (op)
      MODE_PUSH, MODE_OVERWRITE: begin
        if (!ring_full) begin
          ring_mem[ring_tail] = wd;
          ring_tail = ring_next(ring_tail);
          ring_full = (ring_head == ring_tail);
        end else if (op == MODE_OVERWRITE) begin
          // replace the oldest byte, ring stays full
          ring_mem[ring_head] = wd;
          ring_head = ring_next(ring_head);
          ring_tail = ring_next(ring_tail);
          n_ovw++;
        end else begin
          r.status = ST_FULL;
          n_reject++;
        end
      end
      MODE_READ: begin
        if (ring_empty()) begin
          r.status = ST_EMPTY;
          n_empty_rd++;
        end else begin
          r.read_data = ring_mem[ring_head];
          ring_mem[ring_head] = '0;
          ring_head = ring_next(ring_head);
          ring_full = 1'b0;
        end
      end
      default: begin
        ring_restart();
        for (int i = 0; i < cap; i++) ring_mem[i] = '0;
        n_clear++;
      end
    endcase
    last = (ring_tail == 0) ? cap - 1 : ring_tail - 1;
    r.occupancy   = CAP_W'(ring_count());
    r.is_empty    = ring_empty();
    r.is_full     = ring_full;
    r.newest_data = ring_mem[last];
    return r;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic cmp_field(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want_v, got_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    fifo_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      if (expected_rsp_q.size() == 0) begin
        $error("result transfer with no pending operation");
        n_fail++;
      end else begin
        want = expected_rsp_q.pop_front();
        cmp_field("status", 8'(want.status), 8'(rsp_ch.status));
        cmp_field("read_data", want.read_data, rsp_ch.read_data);
        cmp_field("occupancy", 8'(want.occupancy), 8'(rsp_ch.occupancy));
        cmp_field("is_empty", 8'(want.is_empty), 8'(rsp_ch.is_empty));
        cmp_field("is_full", 8'(want.is_full), 8'(rsp_ch.is_full));
        cmp_field("newest_data", want.newest_data, rsp_ch.newest_data);
      end
    end
  end

  task automatic apb_access(input bit wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_CAPACITY;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity_reg();
    logic [PDATA_W-1:0] got;
    apb_access(1'b0, '0, got);
    if (got !== PDATA_W'(cap_reg)) begin
      $error("capacity: expected 0x%0h, got 0x%0h", cap_reg, got);
      n_fail++;
    end
  endtask

  // only the low bits land in the register; upper bits carry noise half the time
  task automatic set_capacity(input int unsigned cap_val);
    logic [PDATA_W-1:0] wd;
    logic [PDATA_W-1:0] unused_rd;
    wd = $urandom();
    if ($urandom_range(1) == 0) wd = '0;
    wd[CAP_W-1:0] = CAP_W'(cap_val);
    apb_access(1'b1, wd, unused_rd);
    cap_reg = wd[CAP_W-1:0];
    ring_restart();
    n_cfg++;
    check_capacity_reg();
  endtask

  task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] wd);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.mode       <= op;
    cmd_ch.write_data <= wd;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_rsp_q.push_back(ring_step(op, wd));
    n_items++;
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int unsigned pick_capacity();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 0;
      1:       return $urandom_range(65, 127);
      2:       return RING_DEPTH;
      3:       return $urandom_range(9, 63);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // mostly fill / overwrite / drain runs sized from the current occupancy or capacity
  task automatic random_burst_traffic(input int n);
    int         sent;
    int         kind;
    int         len;
    int         pick;
    logic [1:0] op;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind <= 2) begin
        len = ring_cap() - ring_count() + $urandom_range(2);
        repeat (len) begin
          op = ($urandom_range(3) == 0) ? MODE_OVERWRITE : MODE_PUSH;
          send_item(op, 8'($urandom_range(255)));
        end
      end else if (kind <= 4) begin
        len = $urandom_range(1, ring_cap() + 1);
        repeat (len) send_item(MODE_OVERWRITE, 8'($urandom_range(255)));
      end else if (kind <= 6) begin
        len = ring_count() + $urandom_range(2);
        repeat (len) send_item(MODE_READ, 8'($urandom_range(255)));
      end else if (kind <= 8) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          pick = $urandom_range(19);
          if (pick < 7)       op = MODE_PUSH;
          else if (pick < 12) op = MODE_OVERWRITE;
          else if (pick < 19) op = MODE_READ;
          else                op = MODE_CLEAR;
          send_item(op, 8'($urandom_range(255)));
        end
      end else begin
        len = 1;
        send_item(MODE_CLEAR, 8'($urandom_range(255)));
      end
      sent += len;
    end
  endtask

  task automatic test_reset_defaults();
    check_capacity_reg();
    send_item(MODE_READ, 8'h00);
    wait_idle();
  endtask

  task automatic test_basic_ops();
    send_item(MODE_PUSH, 8'h00);
    send_item(MODE_PUSH, 8'hFF);
    // not full: acts as a plain push
    send_item(MODE_OVERWRITE, 8'hA5);
    repeat (4) send_item(MODE_READ, 8'h00);
    send_item(MODE_CLEAR, 8'h00);
    wait_idle();
  endtask

  task automatic test_capacity_edges();
    set_capacity(2);
    send_item(MODE_PUSH, 8'h11);
    send_item(MODE_PUSH, 8'h22);
    send_item(MODE_PUSH, 8'h33);
    send_item(MODE_OVERWRITE, 8'h44);
    repeat (3) send_item(MODE_READ, 8'h00);
    send_item(MODE_PUSH, 8'h66);
    send_item(MODE_CLEAR, 8'hFF);
    wait_idle();
    // zero saturates to a single slot
    set_capacity(0);
    send_item(MODE_PUSH, 8'h5A);
    send_item(MODE_OVERWRITE, 8'hC3);
    send_item(MODE_READ, 8'h00);
    wait_idle();
    set_capacity(127);
    send_item(MODE_PUSH, 8'h7E);
    wait_idle();
    // new capacity empties the ring but keeps slot contents
    set_capacity(3);
    send_item(MODE_READ, 8'h00);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int idle_mix [4];
    int stall_mix [4];
    idle_mix  = '{0, 50, 0, 32};
    stall_mix = '{0, 0, 50, 32};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      repeat (4) begin
        set_capacity(pick_capacity());
        random_burst_traffic(90);
        wait_idle();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    set_capacity(RING_DEPTH);
    hold_req = ~hold_req;
    repeat (70) send_item(MODE_PUSH, 8'($urandom_range(255)));
    repeat (10) send_item(MODE_OVERWRITE, 8'($urandom_range(255)));
    repeat (30) send_item(MODE_READ, 8'h00);
    wait_idle();
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = MODE_PUSH;
    cmd_ch.write_data = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_req          = 1'b0;
    n_fail = 0; n_items = 0; n_results = 0; n_cfg = 0;
    n_reject = 0; n_empty_rd = 0; n_ovw = 0; n_clear = 0;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    cap_reg = CAP_RESET;
    ring_restart();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_basic_ops();
    test_capacity_edges();
    test_random_traffic();
    test_backpressure();
    wait_idle();

    $display("Ran %0d operations (%0d results) across %0d capacity writes, four idle mixes",
             n_items, n_results, n_cfg);
    $display("and a long receiver hold-off: %0d rejected pushes, %0d empty reads,",
             n_reject, n_empty_rd);
    $display("%0d full overwrites, %0d clears", n_ovw, n_clear);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/brf_pkg.sv
hdl/brf_channels.sv
hdl/brf_ram.sv
hdl/brf_ctrl.sv
hdl/brf_datapath.sv
hdl/byte_ring_fifo_overwrite.sv
test/tb_byte_ring_fifo_overwrite.sv
